// ----- rtl/sdip_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdip_pkg
// Shared types and constants for the strict decimal integer parser.
// ---------------------------------------------------------------------------
package sdip_pkg;

  // Default longest string whose character positions are told apart.
  localparam int unsigned DEFAULT_MAX_LEN = 1024;

  // Fixed field widths of the stream items.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned EPOS_W  = 10;
  localparam int unsigned OUT_W   = 48;

  // Character codes of interest.
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Magnitude limits for the two signs.
  localparam logic [35:0] LIMIT_POS = 36'h0_7FFF_FFFF;
  localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

  typedef enum logic [CODE_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_SIGN_ONLY = 3'd2,
    ERR_EXTRA     = 3'd3,
    ERR_INVALID   = 3'd4,
    ERR_LEADZERO  = 3'd5,
    ERR_OVERFLOW  = 3'd6
  } err_code_e;

endpackage

// ----- rtl/strict_decimal_int_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strict_decimal_int_parser
// Streams a decimal string in, one character per item, and returns its
// signed 32-bit value together with an error code and error position.
// ---------------------------------------------------------------------------
// Usage
// The input channel carries one character per item in s_axis_tdata_i. When
// s_axis_tuser_i is high the item carries no character; with s_axis_tlast_i
// it ends the string without adding a character, without it the item is simply dropped. The
// item with s_axis_tlast_i high ends the string and produces exactly one
// result item on the output channel; all other items produce none.
// Each character is folded into the running state in the cycle it is
// accepted: a multiply by ten (two shifts and an add), a range check against
// the signed limit and the error ranking form a single short path. The
// result is written to the output register on the edge that accepts the
// final item, so it is visible in the cycle after.
// Throughput is one item per cycle; the input is only held off while a
// result sits in the output register and the receiver is not taking it.
// Reset clears the parse state and empties the output register. A string
// of any length is accepted; character positions saturate at MAX_LEN - 1
// and reported positions carry their low ten bits.
// ---------------------------------------------------------------------------
module strict_decimal_int_parser
  import sdip_pkg::*;
#(
  parameter int unsigned MAX_LEN = DEFAULT_MAX_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel.
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CHAR_W-1:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic              s_axis_tuser_i,   // [0] no_char
  input  logic              s_axis_tlast_i,   // end_of_string
  // Result channel.
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o    // [31:0] parsed_value,
                                              // [34:32] error_code,
                                              // [44:35] error_position,
                                              // [47:45] zero
);

  // Counter wide enough to hold MAX_LEN itself; positions need one less.
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned EXT_W = (POS_W > EPOS_W) ? POS_W : EPOS_W;

  // Parse state.
  logic [CNT_W-1:0]  char_pos_q, char_pos_upd, char_pos_d;
  logic              neg_q, neg_upd, neg_d;
  logic [1:0]        dcnt_q, dcnt_upd, dcnt_d;
  logic              fdz_q, fdz_upd, fdz_d;
  logic              start_q, start_upd, start_d;
  logic [VALUE_W-1:0] acc_q, acc_upd, acc_d;
  err_code_e         herr_q, herr_upd, herr_d;
  logic [EPOS_W-1:0] hpos_q, hpos_upd, hpos_d;
  logic              ovf_q, ovf_upd, ovf_d;
  logic [EPOS_W-1:0] opos_q, opos_upd, opos_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic              in_fire;
  logic              take_char;
  logic              is_sign;
  logic              is_digit;
  logic [3:0]        digit;
  logic [POS_W-1:0]  pos_sat;
  logic [EXT_W-1:0]  pos_ext;
  logic [EPOS_W-1:0] pos10;
  logic [35:0]       acc_wide;
  logic [35:0]       acc_next;
  logic [35:0]       limit;

  err_code_e         res_code;
  logic [EPOS_W-1:0] res_pos;
  logic [VALUE_W-1:0] res_value;

  // The output register parts the two sides: a new item is taken whenever
  // the register is empty or its contents leave in this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign take_char       = in_fire && !s_axis_tuser_i;

  assign is_sign  = (s_axis_tdata_i == CHAR_PLUS) || (s_axis_tdata_i == CHAR_MINUS);
  assign is_digit = (s_axis_tdata_i >= CHAR_ZERO) && (s_axis_tdata_i <= CHAR_NINE);
  assign digit    = 4'(s_axis_tdata_i - CHAR_ZERO);

  // Position of the current character, held at the last index once the
  // counter has reached MAX_LEN.
  assign pos_sat = (char_pos_q == CNT_W'(MAX_LEN)) ? POS_W'(MAX_LEN - 1)
                                                   : char_pos_q[POS_W-1:0];
  assign pos_ext = EXT_W'(pos_sat);
  assign pos10   = pos_ext[EPOS_W-1:0];

  // Times ten as eight plus two, then the new digit.
  assign acc_wide = {4'd0, acc_q};
  assign acc_next = (acc_wide << 3) + (acc_wide << 1) + 36'(digit);
  assign limit    = neg_q ? LIMIT_NEG : LIMIT_POS;

  // State after the character of this item has been taken in.
  always_comb begin
    char_pos_upd = char_pos_q;
    neg_upd      = neg_q;
    dcnt_upd     = dcnt_q;
    fdz_upd      = fdz_q;
    start_upd    = start_q;
    acc_upd      = acc_q;
    herr_upd     = herr_q;
    hpos_upd     = hpos_q;
    ovf_upd      = ovf_q;
    opos_upd     = opos_q;
    if (take_char) begin
      if ((char_pos_q == '0) && is_sign) begin
        // A leading sign sets the polarity and shifts the digit start.
        neg_upd   = (s_axis_tdata_i == CHAR_MINUS);
        start_upd = 1'b1;
      end else if (is_sign) begin
        if (herr_q == ERR_NONE) begin
          herr_upd = ERR_EXTRA;
          hpos_upd = pos10;
        end
      end else if (!is_digit) begin
        if (herr_q == ERR_NONE) begin
          herr_upd = ERR_INVALID;
          hpos_upd = pos10;
        end
      end else begin
        if (dcnt_q == 2'd0) begin
          fdz_upd = (digit == 4'd0);
        end
        if (dcnt_q != 2'd2) begin
          dcnt_upd = dcnt_q + 2'd1;
        end
        // The accumulator freezes at the first digit that passes the limit.
        if (!ovf_q) begin
          if (acc_next > limit) begin
            ovf_upd  = 1'b1;
            opos_upd = pos10;
          end else begin
            acc_upd = acc_next[VALUE_W-1:0];
          end
        end
      end
      if (char_pos_q != CNT_W'(MAX_LEN)) begin
        char_pos_upd = char_pos_q + CNT_W'(1);
      end
    end
  end

  // Error ranking on the updated state.
  always_comb begin
    res_code  = ERR_NONE;
    res_pos   = '0;
    res_value = '0;
    if (char_pos_upd == '0) begin
      res_code = ERR_EMPTY;
    end else if ((char_pos_upd == CNT_W'(1)) && start_upd) begin
      res_code = ERR_SIGN_ONLY;
    end else if (herr_upd != ERR_NONE) begin
      res_code = herr_upd;
      res_pos  = hpos_upd;
    end else if (fdz_upd && (dcnt_upd == 2'd2)) begin
      res_code = ERR_LEADZERO;
      res_pos  = EPOS_W'(start_upd);
    end else if (ovf_upd) begin
      res_code = ERR_OVERFLOW;
      res_pos  = opos_upd;
    end else begin
      res_value = neg_upd ? (VALUE_W'(0) - acc_upd) : acc_upd;
    end
  end

  // Next state: the string's last item returns everything to reset values.
  always_comb begin
    char_pos_d = char_pos_upd;
    neg_d      = neg_upd;
    dcnt_d     = dcnt_upd;
    fdz_d      = fdz_upd;
    start_d    = start_upd;
    acc_d      = acc_upd;
    herr_d     = herr_upd;
    hpos_d     = hpos_upd;
    ovf_d      = ovf_upd;
    opos_d     = opos_upd;
    if (in_fire && s_axis_tlast_i) begin
      char_pos_d = '0;
      neg_d      = 1'b0;
      dcnt_d     = 2'd0;
      fdz_d      = 1'b0;
      start_d    = 1'b0;
      acc_d      = '0;
      herr_d     = ERR_NONE;
      hpos_d     = '0;
      ovf_d      = 1'b0;
      opos_d     = '0;
    end
  end

  // Output register load and drain.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire && s_axis_tlast_i) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, res_pos, res_code, res_value};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q  <= '0;
      neg_q       <= 1'b0;
      dcnt_q      <= 2'd0;
      fdz_q       <= 1'b0;
      start_q     <= 1'b0;
      acc_q       <= '0;
      herr_q      <= ERR_NONE;
      hpos_q      <= '0;
      ovf_q       <= 1'b0;
      opos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      char_pos_q  <= char_pos_d;
      neg_q       <= neg_d;
      dcnt_q      <= dcnt_d;
      fdz_q       <= fdz_d;
      start_q     <= start_d;
      acc_q       <= acc_d;
      herr_q      <= herr_d;
      hpos_q      <= hpos_d;
      ovf_q       <= ovf_d;
      opos_q      <= opos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // Input is held off only while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // The last item of a string always leaves a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("string end produced no result");

  // An error result carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[34:32] != ERR_NONE))
      |-> (m_axis_tdata_o[31:0] == '0))
    else $error("error result with non-zero value");

  // Only positional errors report a position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ((m_axis_tdata_o[34:32] == ERR_NONE) ||
                         (m_axis_tdata_o[34:32] == ERR_EMPTY) ||
                         (m_axis_tdata_o[34:32] == ERR_SIGN_ONLY)))
      |-> (m_axis_tdata_o[44:35] == '0))
    else $error("position reported for a non-positional result");
`endif

endmodule
